[src/pts_pkg.sv]
package pts_pkg;

	localparam int OpW    = 4;
	localparam int IdW    = 4;
	localparam int PrioW  = 3;
	localparam int WaitW  = 16;
	localparam int RsnW   = 8;
	localparam int StatW  = 2;
	localparam int WokenW = 5;
	localparam int OrdW   = 32;

	typedef enum logic [2:0] {
		ST_FREE    = 3'd0,
		ST_DELAYED = 3'd1,
		ST_BLOCKED = 3'd2,
		ST_READY   = 3'd3,
		ST_ACTIVE  = 3'd4
	} slot_st_t;

	typedef enum logic [OpW-1:0] {
		OP_CREATE      = 4'd0,
		OP_YIELD       = 4'd1,
		OP_DELAY       = 4'd2,
		OP_BLOCK       = 4'd3,
		OP_UNBLOCK     = 4'd4,
		OP_UNBLOCK_DLY = 4'd5,
		OP_DESTROY     = 4'd6,
		OP_TICK        = 4'd7,
		OP_START       = 4'd8
	} op_t;

	typedef enum logic [StatW-1:0] {
		STAT_DONE     = 2'd0,
		STAT_IGNORED  = 2'd1,
		STAT_REJECTED = 2'd2
	} status_t;

	typedef struct packed {
		slot_st_t               st;
		logic [PrioW-1:0]       prio;
		logic [WaitW-1:0]       wt;
		logic [OrdW-1:0]        ord;
	} slot_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CHK,
		S_PRE,
		S_BEST,
		S_DEC,
		S_DUE,
		S_FIN
	} fsm_t;

	typedef enum logic {
		CONT_PRE,
		CONT_DISP
	} cont_t;

endpackage

[src/pts_in_if.sv]
interface pts_in_if;
	logic                        valid;
	logic                        ready;
	logic [pts_pkg::OpW-1:0]     op;
	logic [pts_pkg::IdW-1:0]     task_id;
	logic [pts_pkg::PrioW-1:0]   priority_req;
	logic [pts_pkg::WaitW-1:0]   delay_ticks;
	logic [pts_pkg::RsnW-1:0]    block_reason;

	modport source (output valid, op, task_id, priority_req, delay_ticks, block_reason,
		input ready);
	modport sink (input valid, op, task_id, priority_req, delay_ticks, block_reason,
		output ready);
endinterface

[src/pts_out_if.sv]
interface pts_out_if;
	logic                        valid;
	logic                        ready;
	logic [pts_pkg::StatW-1:0]   status;
	logic [pts_pkg::IdW-1:0]     active_id;
	logic                        active_valid;
	logic                        switched;
	logic [pts_pkg::WokenW-1:0]  woken_count;

	modport source (output valid, status, active_id, active_valid, switched, woken_count,
		input ready);
	modport sink (input valid, status, active_id, active_valid, switched, woken_count,
		output ready);
endinterface

[src/pts_ram.sv]
module pts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[src/priority_task_scheduler_unit.sv]
// Priority task scheduler.
// req carries one scheduler event per transfer (op, task_id, priority_req,
// delay_ticks, block_reason); rsp returns exactly one result per event
// (status, active_id, active_valid, switched, woken_count).
// cfg_we/cfg_wdata write preempt_enable (reset 1); the user must write it
// only while the block is idle, which the block itself does not enforce.
// All slot data sits in one RAM, one word per slot, with a registered read.
// Refused ops, create, an unblock miss and destroy of a task not running need
// no table walk; yield, delay, block, start and destroy of the running task
// walk it once. Unblock walks it once if preemption is on and a task runs,
// and once more if it preempts; tick walks it once to count down delays, once
// per task woken and once more, then checks preemption as unblock does.
// The table walk reads one slot per cycle on the single read port.
// req.ready is high only between events; a result waits in the rsp register
// while the next event is taken, and the block holds its next result until
// the receiver takes the previous one.
// Reset (arst_n low) frees all slots, clears the run state and order counter
// and sets preempt_enable; per-slot valid bits make unwritten RAM read as free.
module priority_task_scheduler_unit #(
	parameter int TASK_SLOTS      = 16,
	parameter int PRIORITY_LEVELS = 8
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cfg_we,
	input  logic  cfg_wdata,
	pts_in_if.sink    req,
	pts_out_if.source rsp
);
	localparam int IdxW  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int CntW  = $clog2(TASK_SLOTS + 1);
	localparam int SlotW = $bits(pts_pkg::slot_t);

	pts_pkg::fsm_t    state_q, state_d;
	pts_pkg::cont_t   cont_q, cont_d;
	pts_pkg::status_t status_q, status_d;
	logic             status_ld;

	logic                          preempt_q;
	logic [pts_pkg::OrdW-1:0]      ctr_q;
	logic [IdxW-1:0]               run_idx_q;
	logic                          run_vld_q;
	logic [pts_pkg::PrioW-1:0]     run_prio_q;
	logic [IdxW-1:0]               prev_idx_q;
	logic                          prev_vld_q;
	logic [CntW-1:0]               woken_q;
	logic [CntW-1:0]               cnt_q;
	logic                          rd_s1;
	logic [IdxW-1:0]               addr_s1;
	logic                          found_q;
	logic [IdxW-1:0]               bidx_q;
	pts_pkg::slot_t                bword_q;
	logic [pts_pkg::OrdW-1:0]      bage_q;
	logic [TASK_SLOTS-1:0]         due_q;
	logic [TASK_SLOTS-1:0]         vld_q;
	logic                          rsp_valid_q;

	logic [pts_pkg::OpW-1:0]       op_q;
	logic [IdxW-1:0]               sid_q;
	logic [pts_pkg::PrioW-1:0]     prio_q;
	logic [pts_pkg::RsnW-1:0]      rsn_q;
	pts_pkg::status_t              rsp_status_q;
	logic [pts_pkg::IdW-1:0]       rsp_id_q;
	logic                          rsp_act_q;
	logic                          rsp_sw_q;
	logic [pts_pkg::WokenW-1:0]    rsp_woken_q;

	logic                 mem_we;
	logic [IdxW-1:0]      mem_waddr;
	pts_pkg::slot_t       mem_wdata;
	logic [IdxW-1:0]      mem_raddr;
	logic [SlotW-1:0]     mem_rdata;

	pts_pkg::slot_t            rd_word;
	logic [pts_pkg::OrdW-1:0]  rd_age;
	logic                      accept;
	logic                      id_ok;
	logic                      prio_ok;
	logic                      in_scan;
	logic                      scan_done;
	logic                      scan_issue;
	logic                      best_hit;
	logic                      due_hit;
	logic                      ctr_inc;
	logic                      run_ld;
	logic                      wake;
	logic                      out_ld;

	pts_ram #(
		.WIDTH (SlotW),
		.DEPTH (TASK_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign rd_word    = vld_q[addr_s1] ? pts_pkg::slot_t'(mem_rdata) : '0;
	assign rd_age     = ctr_q - rd_word.ord;
	assign req.ready  = (state_q == pts_pkg::S_IDLE);
	assign accept     = req.valid && req.ready;
	assign id_ok      = 32'(req.task_id) < 32'(TASK_SLOTS);
	assign prio_ok    = 32'(req.priority_req) < 32'(PRIORITY_LEVELS);
	assign in_scan    = (state_q == pts_pkg::S_BEST) || (state_q == pts_pkg::S_DEC) ||
		(state_q == pts_pkg::S_DUE);
	assign scan_done  = in_scan && (cnt_q == CntW'(TASK_SLOTS)) && !rd_s1;
	assign scan_issue = in_scan && (cnt_q != CntW'(TASK_SLOTS));
	assign mem_raddr  = scan_issue ? cnt_q[IdxW-1:0] : sid_q;

	assign best_hit = rd_s1 && (rd_word.st == pts_pkg::ST_READY) && (!found_q ||
		(rd_word.prio > bword_q.prio) ||
		((rd_word.prio == bword_q.prio) && (rd_age > bage_q)));
	assign due_hit  = rd_s1 && due_q[addr_s1] && (!found_q || (rd_age > bage_q));

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.active_id    = rsp_id_q;
	assign rsp.active_valid = rsp_act_q;
	assign rsp.switched     = rsp_sw_q;
	assign rsp.woken_count  = rsp_woken_q;

	always_comb begin
		state_d   = state_q;
		cont_d    = cont_q;
		status_d  = pts_pkg::STAT_DONE;
		status_ld = 1'b0;
		ctr_inc   = 1'b0;
		run_ld    = 1'b0;
		wake      = 1'b0;
		out_ld    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = run_idx_q;
		mem_wdata = '{st: pts_pkg::ST_READY, prio: run_prio_q, wt: '0, ord: ctr_q};
		case (state_q)
			pts_pkg::S_IDLE: begin
				if (accept) begin
					status_ld = 1'b1;
					case (req.op)
						pts_pkg::OP_CREATE: begin
							if (!id_ok || !prio_ok) begin
								status_d = pts_pkg::STAT_REJECTED;
								state_d  = pts_pkg::S_FIN;
							end else begin
								state_d = pts_pkg::S_RD;
							end
						end
						pts_pkg::OP_YIELD, pts_pkg::OP_DELAY, pts_pkg::OP_BLOCK: begin
							if (!run_vld_q || (req.op == pts_pkg::OP_DELAY &&
								req.delay_ticks == '0)) begin
								status_d = pts_pkg::STAT_IGNORED;
								state_d  = pts_pkg::S_FIN;
							end else begin
								mem_we  = 1'b1;
								ctr_inc = 1'b1;
								if (req.op == pts_pkg::OP_DELAY) begin
									mem_wdata.st = pts_pkg::ST_DELAYED;
									mem_wdata.wt = req.delay_ticks;
								end else if (req.op == pts_pkg::OP_BLOCK) begin
									mem_wdata.st = pts_pkg::ST_BLOCKED;
									mem_wdata.wt = pts_pkg::WaitW'(req.block_reason);
								end
								cont_d  = pts_pkg::CONT_DISP;
								state_d = pts_pkg::S_BEST;
							end
						end
						pts_pkg::OP_UNBLOCK, pts_pkg::OP_UNBLOCK_DLY, pts_pkg::OP_DESTROY: begin
							if (!id_ok) begin
								status_d = pts_pkg::STAT_REJECTED;
								state_d  = pts_pkg::S_FIN;
							end else begin
								state_d = pts_pkg::S_RD;
							end
						end
						pts_pkg::OP_TICK: begin
							state_d = pts_pkg::S_DEC;
						end
						pts_pkg::OP_START: begin
							if (run_vld_q) begin
								status_d = pts_pkg::STAT_IGNORED;
								state_d  = pts_pkg::S_FIN;
							end else begin
								cont_d  = pts_pkg::CONT_DISP;
								state_d = pts_pkg::S_BEST;
							end
						end
						default: begin
							status_d = pts_pkg::STAT_IGNORED;
							state_d  = pts_pkg::S_FIN;
						end
					endcase
				end
			end
			pts_pkg::S_RD: begin
				state_d = pts_pkg::S_CHK;
			end
			pts_pkg::S_CHK: begin
				mem_waddr = sid_q;
				state_d   = pts_pkg::S_FIN;
				case (op_q)
					pts_pkg::OP_CREATE: begin
						if (rd_word.st != pts_pkg::ST_FREE) begin
							status_ld = 1'b1;
							status_d  = pts_pkg::STAT_REJECTED;
						end else begin
							mem_we         = 1'b1;
							mem_wdata.prio = prio_q;
							ctr_inc        = 1'b1;
						end
					end
					pts_pkg::OP_UNBLOCK, pts_pkg::OP_UNBLOCK_DLY: begin
						if ((op_q == pts_pkg::OP_UNBLOCK &&
							(rd_word.st != pts_pkg::ST_BLOCKED ||
							rd_word.wt != pts_pkg::WaitW'(rsn_q))) ||
							(op_q == pts_pkg::OP_UNBLOCK_DLY &&
							rd_word.st != pts_pkg::ST_DELAYED)) begin
							status_ld = 1'b1;
							status_d  = pts_pkg::STAT_IGNORED;
						end else begin
							mem_we         = 1'b1;
							mem_wdata.prio = rd_word.prio;
							ctr_inc        = 1'b1;
							state_d        = pts_pkg::S_PRE;
						end
					end
					pts_pkg::OP_DESTROY: begin
						if (rd_word.st == pts_pkg::ST_FREE) begin
							status_ld = 1'b1;
							status_d  = pts_pkg::STAT_IGNORED;
						end else begin
							mem_we    = 1'b1;
							mem_wdata = '{st: pts_pkg::ST_FREE, prio: rd_word.prio, wt: '0,
								ord: rd_word.ord};
							if (run_vld_q && run_idx_q == sid_q) begin
								cont_d  = pts_pkg::CONT_DISP;
								state_d = pts_pkg::S_BEST;
							end
						end
					end
					default: begin
						state_d = pts_pkg::S_FIN;
					end
				endcase
			end
			pts_pkg::S_PRE: begin
				if (preempt_q && run_vld_q) begin
					cont_d  = pts_pkg::CONT_PRE;
					state_d = pts_pkg::S_BEST;
				end else begin
					state_d = pts_pkg::S_FIN;
				end
			end
			pts_pkg::S_BEST: begin
				if (scan_done) begin
					if (cont_q == pts_pkg::CONT_PRE) begin
						if (found_q && bword_q.prio > run_prio_q) begin
							mem_we  = 1'b1;
							ctr_inc = 1'b1;
							cont_d  = pts_pkg::CONT_DISP;
						end else begin
							state_d = pts_pkg::S_FIN;
						end
					end else begin
						run_ld    = 1'b1;
						mem_we    = found_q;
						mem_waddr = bidx_q;
						mem_wdata = bword_q;
						mem_wdata.st = pts_pkg::ST_ACTIVE;
						state_d   = pts_pkg::S_FIN;
					end
				end
			end
			pts_pkg::S_DEC: begin
				mem_waddr = addr_s1;
				mem_wdata = rd_word;
				mem_wdata.wt = (rd_word.wt <= pts_pkg::WaitW'(1)) ? '0 :
					rd_word.wt - pts_pkg::WaitW'(1);
				mem_we = rd_s1 && (rd_word.st == pts_pkg::ST_DELAYED);
				if (scan_done) begin
					state_d = pts_pkg::S_DUE;
				end
			end
			pts_pkg::S_DUE: begin
				if (scan_done) begin
					if (found_q) begin
						mem_we    = 1'b1;
						mem_waddr = bidx_q;
						mem_wdata.prio = bword_q.prio;
						ctr_inc   = 1'b1;
						wake      = 1'b1;
					end else begin
						state_d = pts_pkg::S_PRE;
					end
				end
			end
			pts_pkg::S_FIN: begin
				if (!rsp_valid_q || rsp.ready) begin
					out_ld  = 1'b1;
					state_d = pts_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pts_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pts_pkg::S_IDLE;
			cont_q      <= pts_pkg::CONT_DISP;
			status_q    <= pts_pkg::STAT_DONE;
			preempt_q   <= 1'b1;
			ctr_q       <= '0;
			run_idx_q   <= '0;
			run_vld_q   <= 1'b0;
			run_prio_q  <= '0;
			prev_idx_q  <= '0;
			prev_vld_q  <= 1'b0;
			woken_q     <= '0;
			cnt_q       <= '0;
			rd_s1       <= 1'b0;
			found_q     <= 1'b0;
			due_q       <= '0;
			vld_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cont_q  <= cont_d;
			if (cfg_we) begin
				preempt_q <= cfg_wdata;
			end
			if (status_ld) begin
				status_q <= status_d;
			end
			if (ctr_inc) begin
				ctr_q <= ctr_q + pts_pkg::OrdW'(1);
			end
			if (mem_we) begin
				vld_q[mem_waddr] <= 1'b1;
			end
			if (accept) begin
				prev_idx_q <= run_idx_q;
				prev_vld_q <= run_vld_q;
				woken_q    <= '0;
			end
			if (run_ld) begin
				run_vld_q  <= found_q;
				run_idx_q  <= found_q ? bidx_q : '0;
				run_prio_q <= found_q ? bword_q.prio : '0;
			end
			if (state_q == pts_pkg::S_DEC && rd_s1 &&
				rd_word.st == pts_pkg::ST_DELAYED && rd_word.wt <= pts_pkg::WaitW'(1)) begin
				due_q[addr_s1] <= 1'b1;
			end
			if (wake) begin
				due_q[bidx_q] <= 1'b0;
				woken_q       <= woken_q + CntW'(1);
			end
			rd_s1 <= scan_issue;
			if (!in_scan || scan_done) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (scan_issue) begin
					cnt_q <= cnt_q + CntW'(1);
				end
				if ((state_q == pts_pkg::S_BEST && best_hit) ||
					(state_q == pts_pkg::S_DUE && due_hit)) begin
					found_q <= 1'b1;
				end
			end
			if (out_ld) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= mem_raddr;
		if (accept) begin
			op_q   <= req.op;
			sid_q  <= IdxW'(req.task_id);
			prio_q <= req.priority_req;
			rsn_q  <= req.block_reason;
		end
		if ((state_q == pts_pkg::S_BEST && best_hit) ||
			(state_q == pts_pkg::S_DUE && due_hit)) begin
			bidx_q  <= addr_s1;
			bword_q <= rd_word;
			bage_q  <= rd_age;
		end
		if (out_ld) begin
			rsp_status_q <= status_q;
			rsp_id_q     <= run_vld_q ? pts_pkg::IdW'(run_idx_q) : '0;
			rsp_act_q    <= run_vld_q;
			rsp_sw_q     <= (run_vld_q != prev_vld_q) ||
				(run_vld_q && run_idx_q != prev_idx_q);
			rsp_woken_q  <= pts_pkg::WokenW'(woken_q);
		end
	end
endmodule

[src/pts_checker.sv]
module pts_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [pts_pkg::StatW-1:0]      rsp_status,
	input logic [pts_pkg::IdW-1:0]        rsp_active_id,
	input logic                           rsp_active_valid,
	input logic [pts_pkg::WokenW-1:0]     rsp_woken_count
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
		$stable(rsp_active_id))
		else $error("rsp dropped or changed while stalled");

	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second event taken before result");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status == pts_pkg::STAT_DONE ||
		rsp_status == pts_pkg::STAT_IGNORED || rsp_status == pts_pkg::STAT_REJECTED)
		else $error("bad status");

	a_idle_id: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_active_valid |-> rsp_active_id == '0)
		else $error("active_id set with no running task");

	a_woken_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_woken_count != '0 |-> rsp_status == pts_pkg::STAT_DONE)
		else $error("wake count on a failed event");
endmodule

bind priority_task_scheduler_unit pts_checker u_pts_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_active_id    (rsp.active_id),
	.rsp_active_valid (rsp.active_valid),
	.rsp_woken_count  (rsp.woken_count)
);

[sim/priority_task_scheduler_unit_tb.sv]
module priority_task_scheduler_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOT = 16;
	localparam int NPRIO = 8;

	typedef struct packed {
		logic [pts_pkg::StatW-1:0]  status;
		logic [pts_pkg::IdW-1:0]    active_id;
		logic                       active_valid;
		logic                       switched;
		logic [pts_pkg::WokenW-1:0] woken_count;
	} sched_rsp_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	pts_in_if  req_if();
	pts_out_if rsp_if();

	priority_task_scheduler_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_if.sink),
		.rsp       (rsp_if.source)
	);

	// scheduler shadow
	pts_pkg::slot_st_t          sh_state [NSLOT];
	logic [pts_pkg::PrioW-1:0]  sh_prio  [NSLOT];
	logic [pts_pkg::WaitW-1:0]  sh_wait  [NSLOT];
	logic [pts_pkg::OrdW-1:0]   sh_stamp [NSLOT];
	logic [pts_pkg::OrdW-1:0]   sh_counter;
	logic [pts_pkg::IdW-1:0]    sh_run;
	logic                       sh_run_valid;
	logic                       sh_preempt;

	sched_rsp_t expected_rsp[$];
	int mismatches;
	int rsp_seen;
	int in_gap_pct;
	int out_gap_pct;
	int hold_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("[priority_task_scheduler_unit] ERROR");
		$finish;
	end

	function automatic void stamp_slot(int s);
		sh_stamp[s] = sh_counter;
		sh_counter  = sh_counter + pts_pkg::OrdW'(1);
	endfunction

	function automatic logic [pts_pkg::OrdW-1:0] age_of_slot(int s);
		return sh_counter - sh_stamp[s];
	endfunction

	function automatic int pick_best();
		int b;
		b = -1;
		for (int i = 0; i < NSLOT; i++) begin
			if (sh_state[i] != pts_pkg::ST_READY) continue;
			if (b < 0 || sh_prio[i] > sh_prio[b] ||
			    (sh_prio[i] == sh_prio[b] && age_of_slot(i) > age_of_slot(b)))
				b = i;
		end
		return b;
	endfunction

	function automatic void run_best();
		int b;
		b = pick_best();
		if (b >= 0) begin
			sh_state[b]  = pts_pkg::ST_ACTIVE;
			sh_run       = pts_pkg::IdW'(b);
			sh_run_valid = 1'b1;
		end else begin
			sh_run       = '0;
			sh_run_valid = 1'b0;
		end
	endfunction

	function automatic void requeue_current();
		sh_state[sh_run] = pts_pkg::ST_READY;
		stamp_slot(int'(sh_run));
		run_best();
	endfunction

	function automatic void check_preempt();
		int b;
		if (!sh_preempt || !sh_run_valid) return;
		b = pick_best();
		if (b >= 0 && sh_prio[b] > sh_prio[sh_run]) requeue_current();
	endfunction

	function automatic void shadow_reset();
		for (int i = 0; i < NSLOT; i++) begin
			sh_state[i] = pts_pkg::ST_FREE;
			sh_prio[i]  = '0;
			sh_wait[i]  = '0;
			sh_stamp[i] = '0;
		end
		sh_counter   = '0;
		sh_run       = '0;
		sh_run_valid = 1'b0;
		sh_preempt   = 1'b1;
	endfunction

	function automatic sched_rsp_t schedule_event(logic [pts_pkg::OpW-1:0] op,
			logic [pts_pkg::IdW-1:0] id, logic [pts_pkg::PrioW-1:0] pr,
			logic [pts_pkg::WaitW-1:0] dly, logic [pts_pkg::RsnW-1:0] rsn);
		sched_rsp_t r;
		logic pv;
		logic [pts_pkg::IdW-1:0] ps;
		bit due [NSLOT];
		int woken;
		int pick;
		pv = sh_run_valid;
		ps = sh_run;
		woken = 0;
		r.status = pts_pkg::STAT_DONE;
		case (op)
			pts_pkg::OP_CREATE: begin
				if (int'(pr) >= NPRIO || sh_state[id] != pts_pkg::ST_FREE) begin
					r.status = pts_pkg::STAT_REJECTED;
				end else begin
					sh_state[id] = pts_pkg::ST_READY;
					sh_prio[id]  = pr;
					sh_wait[id]  = '0;
					stamp_slot(int'(id));
				end
			end
			pts_pkg::OP_YIELD: begin
				if (!sh_run_valid) r.status = pts_pkg::STAT_IGNORED;
				else requeue_current();
			end
			pts_pkg::OP_DELAY, pts_pkg::OP_BLOCK: begin
				if (!sh_run_valid || (op == pts_pkg::OP_DELAY && dly == '0)) begin
					r.status = pts_pkg::STAT_IGNORED;
				end else begin
					sh_state[sh_run] = (op == pts_pkg::OP_DELAY) ? pts_pkg::ST_DELAYED :
						pts_pkg::ST_BLOCKED;
					sh_wait[sh_run]  = (op == pts_pkg::OP_DELAY) ? dly :
						pts_pkg::WaitW'(rsn);
					stamp_slot(int'(sh_run));
					run_best();
				end
			end
			pts_pkg::OP_UNBLOCK, pts_pkg::OP_UNBLOCK_DLY: begin
				if ((op == pts_pkg::OP_UNBLOCK && (sh_state[id] != pts_pkg::ST_BLOCKED ||
				     sh_wait[id] != pts_pkg::WaitW'(rsn))) ||
				    (op == pts_pkg::OP_UNBLOCK_DLY &&
				     sh_state[id] != pts_pkg::ST_DELAYED)) begin
					r.status = pts_pkg::STAT_IGNORED;
				end else begin
					sh_state[id] = pts_pkg::ST_READY;
					sh_wait[id]  = '0;
					stamp_slot(int'(id));
					check_preempt();
				end
			end
			pts_pkg::OP_DESTROY: begin
				if (sh_state[id] == pts_pkg::ST_FREE) begin
					r.status = pts_pkg::STAT_IGNORED;
				end else begin
					sh_state[id] = pts_pkg::ST_FREE;
					sh_wait[id]  = '0;
					if (sh_run_valid && sh_run == id) run_best();
				end
			end
			pts_pkg::OP_TICK: begin
				for (int i = 0; i < NSLOT; i++) begin
					due[i] = 1'b0;
					if (sh_state[i] == pts_pkg::ST_DELAYED) begin
						if (sh_wait[i] <= pts_pkg::WaitW'(1)) begin
							sh_wait[i] = '0;
							due[i] = 1'b1;
						end else begin
							sh_wait[i] = sh_wait[i] - pts_pkg::WaitW'(1);
						end
					end
				end
				forever begin
					pick = -1;
					for (int i = 0; i < NSLOT; i++)
						if (due[i] && (pick < 0 || age_of_slot(i) > age_of_slot(pick)))
							pick = i;
					if (pick < 0) break;
					due[pick] = 1'b0;
					sh_state[pick] = pts_pkg::ST_READY;
					stamp_slot(pick);
					woken++;
				end
				check_preempt();
			end
			pts_pkg::OP_START: begin
				if (sh_run_valid) r.status = pts_pkg::STAT_IGNORED;
				else run_best();
			end
			default: r.status = pts_pkg::STAT_IGNORED;
		endcase
		r.active_id    = sh_run_valid ? sh_run : '0;
		r.active_valid = sh_run_valid;
		r.switched     = (sh_run_valid != pv) || (sh_run_valid && sh_run != ps);
		r.woken_count  = pts_pkg::WokenW'(woken);
		return r;
	endfunction

	// valid stays up after a transfer until the next offer or an idle cycle
	task automatic send_event(logic [pts_pkg::OpW-1:0] op,
			logic [pts_pkg::IdW-1:0] id = '0, logic [pts_pkg::PrioW-1:0] pr = '0,
			logic [pts_pkg::WaitW-1:0] dly = '0, logic [pts_pkg::RsnW-1:0] rsn = '0);
		while ($urandom_range(99) < in_gap_pct) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid        <= 1'b1;
		req_if.op           <= op;
		req_if.task_id      <= id;
		req_if.priority_req <= pr;
		req_if.delay_ticks  <= dly;
		req_if.block_reason <= rsn;
		do @(posedge clk); while (!req_if.ready);
		expected_rsp.push_back(schedule_event(op, id, pr, dly, rsn));
		@(negedge clk);
	endtask

	task automatic drain_results();
		req_if.valid <= 1'b0;
		while (expected_rsp.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic write_preempt(logic v);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we     <= 1'b0;
		sh_preempt  = v;
	endtask

	always @(posedge clk) begin
		sched_rsp_t got;
		sched_rsp_t exp;
		if (rsp_if.valid && rsp_if.ready) begin
			got = '{rsp_if.status, rsp_if.active_id, rsp_if.active_valid,
				rsp_if.switched, rsp_if.woken_count};
			rsp_seen++;
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transfer %p", got);
			end else begin
				exp = expected_rsp.pop_front();
				if (got !== exp) begin
					mismatches++;
					if (mismatches <= 10) $display("result mismatch exp %p got %p", exp, got);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= ($urandom_range(99) >= out_gap_pct);
		end
	end

	task automatic test_directed();
		send_event(pts_pkg::OP_START);
		send_event(pts_pkg::OP_YIELD);
		send_event(pts_pkg::OP_DELAY, 0, 0, 16'd5);
		send_event(pts_pkg::OP_BLOCK, 0, 0, 0, 8'hff);
		send_event(pts_pkg::OP_CREATE, 4'd0, 3'd0);
		send_event(pts_pkg::OP_CREATE, 4'd0, 3'd1);
		send_event(pts_pkg::OP_CREATE, 4'd15, 3'd7);
		send_event(pts_pkg::OP_CREATE, 4'd7, 3'd7);
		send_event(pts_pkg::OP_START);
		send_event(pts_pkg::OP_START);
		send_event(pts_pkg::OP_YIELD);
		send_event(pts_pkg::OP_DELAY, 0, 0, 16'd0);
		send_event(pts_pkg::OP_DELAY, 0, 0, 16'hffff);
		send_event(pts_pkg::OP_BLOCK, 0, 0, 0, 8'hff);
		send_event(pts_pkg::OP_UNBLOCK, 4'd7, 0, 0, 8'h00);
		send_event(pts_pkg::OP_UNBLOCK, 4'd7, 0, 0, 8'hff);
		send_event(pts_pkg::OP_UNBLOCK_DLY, 4'd3);
		send_event(pts_pkg::OP_UNBLOCK_DLY, 4'd15);
		send_event(pts_pkg::OP_DELAY, 0, 0, 16'd1);
		send_event(pts_pkg::OP_TICK);
		send_event(pts_pkg::OP_DESTROY, 4'd9);
		send_event(pts_pkg::OP_DESTROY, 4'd15);
		send_event(pts_pkg::OP_DESTROY, 4'd7);
		send_event(4'd9);
		send_event(4'd15);
	endtask

	task automatic random_event();
		int k;
		logic [pts_pkg::OpW-1:0] op;
		k = $urandom_range(99);
		if (k < 18) op = pts_pkg::OP_CREATE;
		else if (k < 28) op = pts_pkg::OP_YIELD;
		else if (k < 38) op = pts_pkg::OP_DELAY;
		else if (k < 46) op = pts_pkg::OP_BLOCK;
		else if (k < 54) op = pts_pkg::OP_UNBLOCK;
		else if (k < 60) op = pts_pkg::OP_UNBLOCK_DLY;
		else if (k < 68) op = pts_pkg::OP_DESTROY;
		else if (k < 88) op = pts_pkg::OP_TICK;
		else if (k < 96) op = pts_pkg::OP_START;
		else op = pts_pkg::OpW'($urandom_range(15));
		send_event(op, pts_pkg::IdW'($urandom_range(15)), pts_pkg::PrioW'($urandom_range(7)),
			($urandom_range(9) == 0) ? pts_pkg::WaitW'($urandom) :
				pts_pkg::WaitW'($urandom_range(6)),
			($urandom_range(4) == 0) ? pts_pkg::RsnW'($urandom) :
				pts_pkg::RsnW'($urandom_range(3)));
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) random_event();
	endtask

	task automatic test_no_gaps();
		in_gap_pct  = 0;
		out_gap_pct = 0;
		test_random(150);
		in_gap_pct  = 22;
		out_gap_pct = 22;
	endtask

	task automatic test_backpressure();
		hold_cycles = 400;
		test_random(20);
		drain_results();
		test_random(20);
	endtask

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = 1'b0;
		req_if.valid        = 1'b0;
		req_if.op           = '0;
		req_if.task_id      = '0;
		req_if.priority_req = '0;
		req_if.delay_ticks  = '0;
		req_if.block_reason = '0;
		rsp_if.ready        = 1'b0;
		mismatches  = 0;
		rsp_seen    = 0;
		hold_cycles = 0;
		in_gap_pct  = 22;
		out_gap_pct = 22;
		shadow_reset();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(300);
		write_preempt(1'b0);
		test_random(250);
		test_no_gaps();
		write_preempt(1'b1);
		test_random(250);
		test_backpressure();
		write_preempt(1'b0);
		write_preempt(1'b1);
		test_random(240);
		drain_results();
		if (mismatches == 0 && expected_rsp.size() == 0) begin
			$display("[priority_task_scheduler_unit] OK");
		end else begin
			$display("[priority_task_scheduler_unit] ERROR");
		end
		$finish;
	end

endmodule

[priority_task_scheduler_unit.f]
src/pts_pkg.sv
src/pts_in_if.sv
src/pts_out_if.sv
src/pts_ram.sv
src/priority_task_scheduler_unit.sv
src/pts_checker.sv
sim/priority_task_scheduler_unit_tb.sv
